[sv/hsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter pipeline
package hsv_pkg;

   // Field widths
   localparam int unsigned ChanW  = 8;
   localparam int unsigned HueW   = 15;

   // Hue scale: 1/64 degree units
   localparam int unsigned HueSextant = 3840;
   localparam int unsigned HueTurn    = 23040;
   localparam int unsigned HueGreenBase = 2 * HueSextant;
   localparam int unsigned HueBlueBase  = 4 * HueSextant;

   // Divider sizes
   localparam int unsigned QHueW = 12;   // hue quotient never exceeds 3840
   localparam int unsigned QSatW = 8;    // saturation quotient never exceeds 255
   localparam int unsigned NHueW = 21;   // 2*3840*255 + 255 fits in 21 bits
   localparam int unsigned NSatW = 16;   // 255*255 + 127 fits in 16 bits
   localparam int unsigned DHueW = 9;    // divisor 2*d
   localparam int unsigned SumW  = 17;   // signed hue before wrap

   // Input transaction
   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic             last_pixel;
   } pix_type;

   // Result transaction
   typedef struct packed {
      logic [HueW-1:0]  hue;
      logic             hue_undefined;
      logic [ChanW-1:0] saturation;
      logic [ChanW-1:0] brightness;
      logic             last_out;
   } hsv_type;

   // Which channel holds the maximum (red wins ties, then green)
   typedef enum logic [1:0] {
      SEXT_RED   = 2'd0,
      SEXT_GREEN = 2'd1,
      SEXT_BLUE  = 2'd2
   } sext_type;

   // After the max/min stage
   typedef struct packed {
      logic [ChanW-1:0]  mx;
      logic [ChanW-1:0]  mn;
      sext_type          sext;
      logic signed [ChanW:0] diff;
      logic              last;
   } ext_type;

   // Working set carried through the divider stages
   typedef struct packed {
      logic [NHueW-1:0] hue_rem;
      logic [DHueW-1:0] hue_div;
      logic [QHueW-1:0] hue_quo;
      logic [NSatW-1:0] sat_rem;
      logic [ChanW-1:0] sat_div;
      logic [QSatW-1:0] sat_quo;
      logic             neg;
      sext_type         sext;
      logic             undef;
      logic             last;
   } div_type;

endpackage

[sv/hsv_front.sv]
// Front end: max/min and sextant selection, then divider operand set-up
module hsv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hsv_pkg::pix_type in_data,
   output logic             in_hold,
   output logic             out_valid,
   output hsv_pkg::div_type out_data,
   input  logic             out_hold
);

   logic             a_valid_ff;
   hsv_pkg::ext_type a_data_ff;
   hsv_pkg::ext_type a_data_in;
   logic             a_hold;

   logic             b_valid_ff;
   hsv_pkg::div_type b_data_ff;
   hsv_pkg::div_type b_data_in;
   logic             b_hold;

   logic [hsv_pkg::ChanW-1:0] mx;
   logic [hsv_pkg::ChanW-1:0] mn;
   logic [hsv_pkg::ChanW-1:0] d;
   logic [hsv_pkg::ChanW:0]   abs_diff;
   logic [hsv_pkg::NHueW-2:0] mag;

   // Hold chain: a stage holds only when full and its successor holds
   assign b_hold  = b_valid_ff && out_hold;
   assign a_hold  = a_valid_ff && b_hold;
   assign in_hold = a_hold;

   // Stage A: largest and smallest channel, sextant and signed difference
   always_comb begin
      mx = in_data.red;
      if (in_data.green > mx) mx = in_data.green;
      if (in_data.blue > mx) mx = in_data.blue;
      mn = in_data.red;
      if (in_data.green < mn) mn = in_data.green;
      if (in_data.blue < mn) mn = in_data.blue;

      a_data_in.mx   = mx;
      a_data_in.mn   = mn;
      a_data_in.last = in_data.last_pixel;
      priority if (in_data.red == mx) begin
         a_data_in.sext = hsv_pkg::SEXT_RED;
         a_data_in.diff = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
      end else if (in_data.green == mx) begin
         a_data_in.sext = hsv_pkg::SEXT_GREEN;
         a_data_in.diff = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
      end else begin
         a_data_in.sext = hsv_pkg::SEXT_BLUE;
         a_data_in.diff = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_hold) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!a_hold) begin
         a_data_ff <= a_data_in;
      end
   end

   // Stage B: range, |diff| * 3840 and the two numerators
   always_comb begin
      d        = a_data_ff.mx - a_data_ff.mn;
      abs_diff = a_data_ff.diff[hsv_pkg::ChanW] ? 9'(-a_data_ff.diff) : 9'(a_data_ff.diff);
      // 3840 = 4096 - 256
      mag      = {abs_diff[hsv_pkg::ChanW-1:0], 12'd0} - {4'd0, abs_diff[hsv_pkg::ChanW-1:0], 8'd0};

      // hue: round(mag / d) as (2*mag + d) / (2*d)
      b_data_in.hue_rem = {mag, 1'b0} + {13'd0, d};
      b_data_in.hue_div = {d, 1'b0};
      b_data_in.hue_quo = '0;
      // saturation: (255*d + max/2) / max
      b_data_in.sat_rem = {d, 8'd0} - {8'd0, d} + {9'd0, a_data_ff.mx[hsv_pkg::ChanW-1:1]};
      b_data_in.sat_div = a_data_ff.mx;
      b_data_in.sat_quo = '0;
      b_data_in.neg     = a_data_ff.diff[hsv_pkg::ChanW];
      b_data_in.sext    = a_data_ff.sext;
      b_data_in.undef   = (d == '0);
      b_data_in.last    = a_data_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_hold) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!b_hold) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

[sv/hsv_div.sv]
// Pipelined restoring divider: one hue quotient bit per stage, plus one saturation quotient bit in each low-order stage
module hsv_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hsv_pkg::div_type in_data,
   output logic             in_hold,
   output logic             out_valid,
   output hsv_pkg::div_type out_data,
   input  logic             out_hold
);

   localparam int unsigned Stages = hsv_pkg::QHueW;

   logic             v_ff  [0:Stages-1];
   hsv_pkg::div_type st_ff [0:Stages-1];
   hsv_pkg::div_type st_in [0:Stages-1];
   logic             hold  [0:Stages-1];

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      localparam int unsigned Bit = Stages - 1 - k;

      logic             src_v;
      hsv_pkg::div_type src;
      logic [hsv_pkg::NHueW-1:0] hdiv_sh;

      // Source is the input port for the first stage, else the stage before
      if (k == 0) begin : g_first
         assign src_v = in_valid;
         assign src   = in_data;
      end else begin : g_next
         assign src_v = v_ff[k-1];
         assign src   = st_ff[k-1];
      end

      if (k == Stages - 1) begin : g_hold_last
         assign hold[k] = v_ff[k] && out_hold;
      end else begin : g_hold_mid
         assign hold[k] = v_ff[k] && hold[k+1];
      end

      assign hdiv_sh = {{(hsv_pkg::NHueW - hsv_pkg::DHueW){1'b0}}, src.hue_div} << Bit;

      if (Bit < hsv_pkg::QSatW) begin : g_sat
         logic [hsv_pkg::NSatW-1:0] sdiv_sh;
         assign sdiv_sh = {{(hsv_pkg::NSatW - hsv_pkg::ChanW){1'b0}}, src.sat_div} << Bit;

         // Hue and saturation steps side by side
         always_comb begin
            st_in[k] = src;
            if (src.hue_rem >= hdiv_sh) begin
               st_in[k].hue_rem      = src.hue_rem - hdiv_sh;
               st_in[k].hue_quo[Bit] = 1'b1;
            end
            if (src.sat_rem >= sdiv_sh) begin
               st_in[k].sat_rem      = src.sat_rem - sdiv_sh;
               st_in[k].sat_quo[Bit] = 1'b1;
            end
         end
      end else begin : g_hue_only
         // Upper hue bits only
         always_comb begin
            st_in[k] = src;
            if (src.hue_rem >= hdiv_sh) begin
               st_in[k].hue_rem      = src.hue_rem - hdiv_sh;
               st_in[k].hue_quo[Bit] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (!hold[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (!hold[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_hold   = hold[0];
   assign out_valid = v_ff[Stages-1];
   assign out_data  = st_ff[Stages-1];

   // Hue quotient stays within one sextant
   a_hue_quo_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.undef |-> out_data.hue_quo <= hsv_pkg::QHueW'(hsv_pkg::HueSextant))
      else $error("hue quotient above one sextant");

   // Division finished: remainders below divisors
   a_hue_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.undef |->
         out_data.hue_rem < {{(hsv_pkg::NHueW - hsv_pkg::DHueW){1'b0}}, out_data.hue_div})
      else $error("hue remainder not reduced");

   a_sat_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.sat_div != '0 |->
         out_data.sat_rem < {{(hsv_pkg::NSatW - hsv_pkg::ChanW){1'b0}}, out_data.sat_div})
      else $error("saturation remainder not reduced");

endmodule

[sv/hsv_back.sv]
// Back end: hue base, sign and wrap, gray override, result register
module hsv_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hsv_pkg::div_type in_data,
   output logic             in_hold,
   output logic             out_valid,
   output hsv_pkg::hsv_type out_data,
   input  logic             out_hold
);

   logic             valid_ff;
   hsv_pkg::hsv_type data_ff;
   hsv_pkg::hsv_type data_in;

   logic [hsv_pkg::SumW-2:0]   base;
   logic signed [hsv_pkg::SumW-1:0] sum;
   logic [hsv_pkg::SumW-1:0]   wrapped;

   assign in_hold = valid_ff && out_hold;

   // Sextant base in 1/64 degree
   always_comb begin
      unique case (in_data.sext)
         hsv_pkg::SEXT_RED:   base = '0;
         hsv_pkg::SEXT_GREEN: base = 16'(hsv_pkg::HueGreenBase);
         hsv_pkg::SEXT_BLUE:  base = 16'(hsv_pkg::HueBlueBase);
         default:             base = '0;
      endcase
   end

   // Signed hue, then wrap a negative value by one turn
   always_comb begin
      if (in_data.neg) begin
         sum = $signed({1'b0, base}) - $signed({5'd0, in_data.hue_quo});
      end else begin
         sum = $signed({1'b0, base}) + $signed({5'd0, in_data.hue_quo});
      end
      if (sum[hsv_pkg::SumW-1]) begin
         wrapped = sum + 17'(hsv_pkg::HueTurn);
      end else begin
         wrapped = sum;
      end

      data_in.hue_undefined = in_data.undef;
      data_in.hue           = in_data.undef ? '0 : wrapped[hsv_pkg::HueW-1:0];
      data_in.saturation    = in_data.undef ? '0 : in_data.sat_quo;
      data_in.brightness    = in_data.sat_div;
      data_in.last_out      = in_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_hold) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/rgb_to_hsv_converter_core.sv]
// Top level of the RGB to HSV converter
// Converts one 8-bit RGB pixel to hue (1/64 degree, 0..23039), saturation
// (255 = 1.0, rounded) and value (largest channel). Gray and black pixels give
// hue 0 with hue_undefined set and saturation 0; last_pixel is carried through.
// One transaction is accepted per clock while req_stall is low. Each result passes
// through two set-up stages, twelve divider stages (one hue quotient bit each, and
// one saturation quotient bit in each low-order stage) and the result register.
// Every stage loads whenever it is empty, so bubbles close up under rsp_stall and
// req_stall rises only once the whole pipeline is full and the result stalls.
module rgb_to_hsv_converter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsv_pkg::pix_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsv_pkg::hsv_type rsp_data
);

   logic             front_valid;
   hsv_pkg::div_type front_data;
   logic             div_hold;
   logic             div_valid;
   hsv_pkg::div_type div_data;
   logic             back_hold;

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_hold   (req_stall),
      .out_valid (front_valid),
      .out_data  (front_data),
      .out_hold  (div_hold)
   );

   hsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .in_hold   (div_hold),
      .out_valid (div_valid),
      .out_data  (div_data),
      .out_hold  (back_hold)
   );

   hsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .in_hold   (back_hold),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_hold  (rsp_stall)
   );

   // Back-pressure only reaches the input through a full result register
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

endmodule

[bench/rgb_to_hsv_converter_core_tb.sv]
// Self-checking testbench for the RGB to HSV converter core
`timescale 1ns / 100ps

module rgb_to_hsv_converter_core_tb;

   localparam int CycleLimit   = 200000;
   localparam int RandomItems  = 1800;
   localparam int DrainCycles  = 40;
   localparam int HoldStart    = 300;   // accepted count that triggers the long hold-off
   localparam int HoldCycles   = 80;
   localparam int QuietFirst   = 700;   // no idling on either side in this window
   localparam int QuietLast    = 1000;
   localparam int DirCount     = 24;

   // One directed row: pixel, whether a typed result is given, and that result
   typedef struct packed {
      hsv_pkg::pix_type pix;
      logic             typed;
      hsv_pkg::hsv_type want;
   } stim_row_type;

   // Directed rows: hsv fields are {hue, hue_undefined, saturation, brightness, last_out}
   localparam stim_row_type DirTab [DirCount] = '{
      // black
      {8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 15'd0,     1'b1, 8'd0,   8'd0,   1'b0},
      // white
      {8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 15'd0,     1'b1, 8'd0,   8'd255, 1'b1},
      // mid gray
      {8'd128, 8'd128, 8'd128, 1'b0, 1'b1, 15'd0,     1'b1, 8'd0,   8'd128, 1'b0},
      // primaries and secondaries at full scale
      {8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 15'd0,     1'b0, 8'd255, 8'd255, 1'b0},
      {8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 15'd7680,  1'b0, 8'd255, 8'd255, 1'b1},
      {8'd0,   8'd0,   8'd255, 1'b0, 1'b1, 15'd15360, 1'b0, 8'd255, 8'd255, 1'b0},
      {8'd255, 8'd255, 8'd0,   1'b0, 1'b1, 15'd3840,  1'b0, 8'd255, 8'd255, 1'b0},
      {8'd0,   8'd255, 8'd255, 1'b1, 1'b1, 15'd11520, 1'b0, 8'd255, 8'd255, 1'b1},
      {8'd255, 8'd0,   8'd255, 1'b0, 1'b1, 15'd19200, 1'b0, 8'd255, 8'd255, 1'b0},
      // smallest non-zero pixels
      {8'd1,   8'd0,   8'd0,   1'b0, 1'b1, 15'd0,     1'b0, 8'd255, 8'd1,   1'b0},
      {8'd0,   8'd0,   8'd1,   1'b1, 1'b1, 15'd15360, 1'b0, 8'd255, 8'd1,   1'b1},
      {8'd1,   8'd1,   8'd1,   1'b0, 1'b1, 15'd0,     1'b1, 8'd0,   8'd1,   1'b0},
      // negative hue that wraps, ties, low saturation and general colours
      {8'd255, 8'd0,   8'd1,   1'b0, 1'b0, 33'd0},
      {8'd255, 8'd1,   8'd0,   1'b1, 1'b0, 33'd0},
      {8'd254, 8'd255, 8'd255, 1'b0, 1'b0, 33'd0},
      {8'd255, 8'd254, 8'd254, 1'b0, 1'b0, 33'd0},
      {8'd1,   8'd1,   8'd0,   1'b0, 1'b0, 33'd0},
      {8'd200, 8'd100, 8'd50,  1'b1, 1'b0, 33'd0},
      {8'd50,  8'd200, 8'd100, 1'b0, 1'b0, 33'd0},
      {8'd100, 8'd50,  8'd200, 1'b0, 1'b0, 33'd0},
      {8'd170, 8'd85,  8'd170, 1'b1, 1'b0, 33'd0},
      {8'd3,   8'd2,   8'd1,   1'b0, 1'b0, 33'd0},
      {8'd0,   8'd128, 8'd255, 1'b1, 1'b0, 33'd0},
      {8'd255, 8'd127, 8'd128, 1'b0, 1'b0, 33'd0}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hsv_pkg::pix_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hsv_pkg::hsv_type rsp_data;

   // Typed result travelling with the current request, if any
   logic             drv_typed = 1'b0;
   hsv_pkg::hsv_type drv_want  = '0;

   hsv_pkg::hsv_type hsv_pending [$];
   hsv_pkg::hsv_type oldest_hsv;
   int      n_accepted = 0;
   int      n_err      = 0;
   int      cycle_cnt  = 0;
   bit      hold_done  = 1'b0;

   rgb_to_hsv_converter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Expected HSV for one pixel, sextant rule with rounded integer divisions
   function automatic hsv_pkg::hsv_type predict_hsv(hsv_pkg::pix_type p);
      int unsigned      r, g, b, mx, mn, d, sat, mag, q;
      int               diff, base, h;
      hsv_pkg::hsv_type res;
      r  = p.red;
      g  = p.green;
      b  = p.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sat = (mx == 0) ? 0 : (255 * d + mx / 2) / mx;
      res = '0;
      res.saturation = sat[7:0];
      res.brightness = mx[7:0];
      res.last_out   = p.last_pixel;
      if (d == 0) begin
         // gray or black: hue has no meaning
         res.hue_undefined = 1'b1;
      end else begin
         // red wins ties, then green
         if (r == mx) begin
            diff = int'(g) - int'(b);
            base = 0;
         end else if (g == mx) begin
            diff = int'(b) - int'(r);
            base = hsv_pkg::HueGreenBase;
         end else begin
            diff = int'(r) - int'(g);
            base = hsv_pkg::HueBlueBase;
         end
         mag = (diff < 0 ? -diff : diff) * hsv_pkg::HueSextant;
         q   = (2 * mag + d) / (2 * d);
         h   = (diff < 0) ? base - int'(q) : base + int'(q);
         if (h < 0) h += hsv_pkg::HueTurn;
         res.hue = h[hsv_pkg::HueW-1:0];
      end
      return res;
   endfunction

   // Random pixel, biased towards grays, ties and extremes
   function automatic hsv_pkg::pix_type random_pixel();
      hsv_pkg::pix_type p;
      logic [7:0]       v, w;
      logic [7:0]       ends [4];
      ends = '{8'd0, 8'd1, 8'd254, 8'd255};
      p.red        = 8'($urandom_range(255));
      p.green      = 8'($urandom_range(255));
      p.blue       = 8'($urandom_range(255));
      p.last_pixel = 1'($urandom_range(1));
      v = 8'($urandom_range(255));
      w = 8'($urandom_range(255));
      case ($urandom_range(9))
         4: begin
            // gray, black and white included
            p.red   = v;
            p.green = v;
            p.blue  = v;
         end
         5: begin
            // two channels tied, the third random
            case ($urandom_range(2))
               0: begin p.red = v;   p.green = v; end
               1: begin p.green = v; p.blue = v;  end
               default: begin p.red = v; p.blue = v; end
            endcase
         end
         6: begin
            p.red   = ends[$urandom_range(3)];
            p.green = ends[$urandom_range(3)];
            p.blue  = ends[$urandom_range(3)];
         end
         7: begin
            p.red   = 8'($urandom_range(3));
            p.green = 8'($urandom_range(3));
            p.blue  = 8'($urandom_range(3));
         end
         8: begin
            // near gray: small spread around a random level
            w       = (v > 8'd250) ? 8'd250 : v;
            p.red   = w + 8'($urandom_range(4));
            p.green = w + 8'($urandom_range(4));
            p.blue  = w + 8'($urandom_range(4));
         end
         9: begin
            p.red   = 8'd255;
            p.green = 8'd0;
            p.blue  = v;
            if ($urandom_range(1) == 1) begin
               p.red   = v;
               p.green = 8'd255;
               p.blue  = w;
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_err++;
      end
   endtask

   // Offer one pixel transaction and hold it until it is taken
   task automatic send_pixel(hsv_pkg::pix_type p, logic typed, hsv_pkg::hsv_type want,
                             bit idle_ok);
      while (idle_ok && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      drv_typed <= typed;
      drv_want  <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Reset, then directed table, random pixels and drain
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DirCount; i++) begin
         send_pixel(DirTab[i].pix, DirTab[i].typed, DirTab[i].want, 1'b1);
      end
      for (int i = 0; i < RandomItems; i++) begin
         send_pixel(random_pixel(), 1'b0, '0, !(i >= QuietFirst && i < QuietLast));
      end
      req_valid <= 1'b0;
      while (hsv_pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (n_err == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: random stall, one long hold-off, quiet window
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && n_accepted >= HoldStart) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_stall <= (n_accepted < QuietFirst + DirCount || n_accepted >= QuietLast + DirCount)
                         && ($urandom_range(99) < 11);
         end
      end
   end

   // Scoreboard: predict on request, compare on result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            hsv_pending.push_back(drv_typed ? drv_want : predict_hsv(req_data));
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (hsv_pending.size() == 0) begin
               $error("result transaction with no expected result pending");
               n_err++;
            end else begin
               oldest_hsv = hsv_pending.pop_front();
               check_field("hue", oldest_hsv.hue, rsp_data.hue);
               check_field("hue_undefined", oldest_hsv.hue_undefined, rsp_data.hue_undefined);
               check_field("saturation", oldest_hsv.saturation, rsp_data.saturation);
               check_field("brightness", oldest_hsv.brightness, rsp_data.brightness);
               check_field("last_out", oldest_hsv.last_out, rsp_data.last_out);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
